// ===== hw/rtl/y2r_pkg.sv =====
// Shared types and constants for the YCbCr 4:2:2 to packed RGB converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package y2r_pkg;

   // Packed pixel format codes.
   localparam logic [3:0] FMT_332         = 4'd0;
   localparam logic [3:0] FMT_233_REV     = 4'd1;
   localparam logic [3:0] FMT_565         = 4'd2;
   localparam logic [3:0] FMT_565_REV     = 4'd3;
   localparam logic [3:0] FMT_4444        = 4'd4;
   localparam logic [3:0] FMT_4444_REV    = 4'd5;
   localparam logic [3:0] FMT_5551        = 4'd6;
   localparam logic [3:0] FMT_1555_REV    = 4'd7;
   localparam logic [3:0] FMT_8888        = 4'd8;
   localparam logic [3:0] FMT_8888_REV    = 4'd9;
   localparam logic [3:0] FMT_1010102     = 4'd10;
   localparam logic [3:0] FMT_2101010_REV = 4'd11;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_WINDOW_X      = 3'd0;
   localparam logic [2:0] REG_WINDOW_Y      = 3'd1;
   localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd2;
   localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd3;
   localparam logic [2:0] REG_PACKED_TYPE   = 3'd4;
   localparam logic [2:0] REG_SWAP_RED_BLUE = 3'd5;

   typedef struct packed {
      logic [9:0]  window_x;
      logic [9:0]  window_y;
      logic [10:0] window_width;
      logic [10:0] window_height;
      logic [3:0]  packed_type;
      logic        swap_red_blue;
   } cfg_type;

   // One lane's finding for the merging stage.
   typedef struct packed {
      logic        hit;
      logic [9:0]  dest_x;
      logic [31:0] pixel;
   } lane_res_type;

endpackage

`default_nettype wire

// ===== hw/rtl/y2r_csr.sv =====
// Configuration register file behind an APB-style port.
// Depends on y2r_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module y2r_csr
   import y2r_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_WINDOW_X:      cfg_in.window_x      = csr_pwdata[9:0];
            REG_WINDOW_Y:      cfg_in.window_y      = csr_pwdata[9:0];
            REG_WINDOW_WIDTH:  cfg_in.window_width  = csr_pwdata[10:0];
            REG_WINDOW_HEIGHT: cfg_in.window_height = csr_pwdata[10:0];
            REG_PACKED_TYPE:   cfg_in.packed_type   = csr_pwdata[3:0];
            REG_SWAP_RED_BLUE: cfg_in.swap_red_blue = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_x      <= '0;
         cfg_ff.window_y      <= '0;
         cfg_ff.window_width  <= '0;
         cfg_ff.window_height <= '0;
         cfg_ff.packed_type   <= FMT_4444_REV;
         cfg_ff.swap_red_blue <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_WINDOW_X:      csr_prdata = {22'd0, cfg_ff.window_x};
         REG_WINDOW_Y:      csr_prdata = {22'd0, cfg_ff.window_y};
         REG_WINDOW_WIDTH:  csr_prdata = {21'd0, cfg_ff.window_width};
         REG_WINDOW_HEIGHT: csr_prdata = {21'd0, cfg_ff.window_height};
         REG_PACKED_TYPE:   csr_prdata = {28'd0, cfg_ff.packed_type};
         REG_SWAP_RED_BLUE: csr_prdata = {31'd0, cfg_ff.swap_red_blue};
         default:           csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/y2r_lane.sv =====
// One conversion lane: registered Q10 products, then sum, clamp, swap and pack.
// Depends on y2r_pkg for the format codes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module y2r_lane
   import y2r_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       load,
   input  wire logic [7:0] luma,
   input  wire logic [7:0] cb,
   input  wire logic [7:0] cr,
   input  wire cfg_type    cfg,
   output logic [31:0]     pixel
);

   logic [18:0] y_prod_ff;
   logic [18:0] cr_r_prod_ff;
   logic [16:0] cb_g_prod_ff;
   logic [17:0] cr_g_prod_ff;
   logic [19:0] cb_b_prod_ff;

   logic signed [21:0] r_sum;
   logic signed [21:0] g_sum;
   logic signed [21:0] b_sum;
   logic [7:0]         r_c;
   logic [7:0]         g_c;
   logic [7:0]         b_c;
   logic [7:0]         r;
   logic [7:0]         b;
   logic [9:0]         r10;
   logic [9:0]         g10;
   logic [9:0]         b10;

   // A negative sum gives 0; otherwise the Q10 value saturates at 255.
   function automatic logic [7:0] clamp_q10(input logic signed [21:0] s);
      logic [7:0] v;
      if (s[21]) begin
         v = 8'd0;
      end else if (|s[20:18]) begin
         v = 8'hFF;
      end else begin
         v = s[17:10];
      end
      return v;
   endfunction

   // floor(c*1023/255) equals 4c + floor(c/85).
   function automatic logic [9:0] to10(input logic [7:0] c);
      logic [1:0] q;
      if (c == 8'd255) begin
         q = 2'd3;
      end else if (c >= 8'd170) begin
         q = 2'd2;
      end else if (c >= 8'd85) begin
         q = 2'd1;
      end else begin
         q = 2'd0;
      end
      return {c, 2'b00} + {8'd0, q};
   endfunction

   always_ff @(posedge clock) begin
      if (load) begin
         y_prod_ff    <= {11'd0, luma} * 19'd1192;
         cr_r_prod_ff <= {11'd0, cr} * 19'd1634;
         cb_g_prod_ff <= {9'd0, cb} * 17'd401;
         cr_g_prod_ff <= {10'd0, cr} * 18'd832;
         cb_b_prod_ff <= {12'd0, cb} * 20'd2066;
      end
   end

   assign r_sum = $signed({3'd0, y_prod_ff}) + $signed({3'd0, cr_r_prod_ff})
                  - 22'sd228271;
   assign g_sum = $signed({3'd0, y_prod_ff}) - $signed({5'd0, cb_g_prod_ff})
                  - $signed({4'd0, cr_g_prod_ff}) + 22'sd138830;
   assign b_sum = $signed({3'd0, y_prod_ff}) + $signed({2'd0, cb_b_prod_ff})
                  - 22'sd283480;

   assign r_c = clamp_q10(r_sum);
   assign g_c = clamp_q10(g_sum);
   assign b_c = clamp_q10(b_sum);

   assign r = cfg.swap_red_blue ? b_c : r_c;
   assign b = cfg.swap_red_blue ? r_c : b_c;

   assign r10 = to10(r);
   assign g10 = to10(g_c);
   assign b10 = to10(b);

   // Alpha is always 255, so its fields are all ones.
   always_comb begin
      case (cfg.packed_type)
         FMT_332:         pixel = {24'd0, r[7:5], g_c[7:5], b[7:6]};
         FMT_233_REV:     pixel = {24'd0, b[7:6], g_c[7:5], r[7:5]};
         FMT_565:         pixel = {16'd0, r[7:3], g_c[7:2], b[7:3]};
         FMT_565_REV:     pixel = {16'd0, b[7:3], g_c[7:2], r[7:3]};
         FMT_4444:        pixel = {16'd0, r[7:4], g_c[7:4], b[7:4], 4'hF};
         FMT_4444_REV:    pixel = {16'd0, 4'hF, b[7:4], g_c[7:4], r[7:4]};
         FMT_5551:        pixel = {16'd0, r[7:3], g_c[7:3], b[7:3], 1'b1};
         FMT_1555_REV:    pixel = {16'd0, 1'b1, b[7:3], g_c[7:3], r[7:3]};
         FMT_8888:        pixel = {r, g_c, b, 8'hFF};
         FMT_8888_REV:    pixel = {8'hFF, b, g_c, r};
         FMT_1010102:     pixel = {r10, g10, b10, 2'b11};
         FMT_2101010_REV: pixel = {2'b11, b10, g10, r10};
         default:         pixel = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/y2r_merge.sv =====
// Merging stage: holds both lanes' results and sends them out one per transaction.
// Depends on y2r_pkg for the lane result struct.
`timescale 1ns / 1ps
`default_nettype none

module y2r_merge
   import y2r_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_take,
   input  wire lane_res_type lane0,
   input  wire lane_res_type lane1,
   input  wire logic [9:0]   dest_y,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [31:0]       rsp_packed_pixel,
   output logic [9:0]        rsp_dest_x,
   output logic [9:0]        rsp_dest_y,
   output logic              rsp_last
);

   logic [1:0]  pend_ff;
   logic [1:0]  pend_in;
   logic [31:0] pix_ff [2];
   logic [9:0]  dx_ff [2];
   logic [9:0]  dy_ff;
   logic        sel;
   logic        fire;
   logic        free;

   // The first pixel always goes out first; last marks a single pending result.
   assign sel       = ~pend_ff[0];
   assign rsp_valid = |pend_ff;
   assign rsp_last  = (pend_ff != 2'b11);
   assign fire      = rsp_valid & ~rsp_stall;
   assign free      = ~rsp_valid | (fire & rsp_last);
   assign in_take   = in_valid & free;

   assign rsp_packed_pixel = pix_ff[sel];
   assign rsp_dest_x       = dx_ff[sel];
   assign rsp_dest_y       = dy_ff;

   always_comb begin
      pend_in = pend_ff;
      if (in_take) begin
         pend_in = {lane1.hit, lane0.hit};
      end else if (fire) begin
         pend_in[sel] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'b00;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         pix_ff[0] <= lane0.pixel;
         pix_ff[1] <= lane1.pixel;
         dx_ff[0]  <= lane0.dest_x;
         dx_ff[1]  <= lane1.dest_x;
         dy_ff     <= dest_y;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ycbcr422_to_packed_rgb.sv =====
// Pipeline: each accepted transaction goes through the first stage, then the merging stage.
// Throughput: one input transaction per cycle unless rsp_stall holds or both pixels lie in
// the window, when the merging stage's single result channel sends them out one at a time.
// Reset: synchronous; empties the pipeline and returns the registers to their reset values
// (window zero, packed type 4444 reversed, no red/blue swap).
// Depends on y2r_pkg, y2r_csr, y2r_lane and y2r_merge.
`timescale 1ns / 1ps
`default_nettype none

module ycbcr422_to_packed_rgb
   import y2r_pkg::*;
#(
   parameter int LINE_MAX = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_pair_word,
   input  wire logic [9:0]  req_column,
   input  wire logic [9:0]  req_row,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_packed_pixel,
   output logic [9:0]       rsp_dest_x,
   output logic [9:0]       rsp_dest_y,
   output logic             rsp_last,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Columns are compared on 13 bits so that any line length up to 8191 fits.
   localparam logic [12:0] LINE_LIMIT = 13'(LINE_MAX);

   cfg_type      cfg;
   logic         accept;
   logic         take;
   logic         s1_valid_ff;
   logic         s1_valid_in;
   logic [10:0]  col0;
   logic [10:0]  col1;
   logic [11:0]  x_end;
   logic [11:0]  y_end;
   logic         row_ok;
   logic         in0;
   logic         in1;
   logic         in0_ff;
   logic         in1_ff;
   logic [9:0]   dx0_ff;
   logic [9:0]   dx1_ff;
   logic [9:0]   dy_ff;
   logic [31:0]  pix0;
   logic [31:0]  pix1;
   lane_res_type lane0;
   lane_res_type lane1;

   y2r_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The first stage holds one transaction; it stalls the input only while the
   // merging stage still has results of an earlier transaction to send.
   assign req_stall = s1_valid_ff & ~take;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Window test for both pixels of the pair. The second pixel may land on
   // column 1024, so columns carry an extra bit.
   assign col0   = {1'b0, req_column};
   assign col1   = col0 + 11'd1;
   assign x_end  = {2'b00, cfg.window_x} + {1'b0, cfg.window_width};
   assign y_end  = {2'b00, cfg.window_y} + {1'b0, cfg.window_height};
   assign row_ok = (req_row >= cfg.window_y) && ({2'b00, req_row} < y_end);
   assign in0    = row_ok && (col0 >= {1'b0, cfg.window_x}) && ({1'b0, col0} < x_end)
                   && ({2'b00, col0} < LINE_LIMIT);
   assign in1    = row_ok && (col1 >= {1'b0, cfg.window_x}) && ({1'b0, col1} < x_end)
                   && ({2'b00, col1} < LINE_LIMIT);

   always_ff @(posedge clock) begin
      if (accept) begin
         in0_ff <= in0;
         in1_ff <= in1;
         dx0_ff <= col0[9:0] - cfg.window_x;
         dx1_ff <= col1[9:0] - cfg.window_x;
         dy_ff  <= req_row - cfg.window_y;
      end
   end

   // Two conversion lanes, one per pixel; both share the pair's chroma.
   y2r_lane u_lane0 (
      .clock (clock),
      .load  (accept),
      .luma  (req_pair_word[31:24]),
      .cb    (req_pair_word[23:16]),
      .cr    (req_pair_word[7:0]),
      .cfg   (cfg),
      .pixel (pix0)
   );

   y2r_lane u_lane1 (
      .clock (clock),
      .load  (accept),
      .luma  (req_pair_word[15:8]),
      .cb    (req_pair_word[23:16]),
      .cr    (req_pair_word[7:0]),
      .cfg   (cfg),
      .pixel (pix1)
   );

   assign lane0 = '{hit: in0_ff, dest_x: dx0_ff, pixel: pix0};
   assign lane1 = '{hit: in1_ff, dest_x: dx1_ff, pixel: pix1};

   // The merging stage registers both results and hands them out in column
   // order; a transaction with no pixel in the window simply drops out there.
   y2r_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (s1_valid_ff),
      .in_take          (take),
      .lane0            (lane0),
      .lane1            (lane1),
      .dest_y           (dy_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_pixel (rsp_packed_pixel),
      .rsp_dest_x       (rsp_dest_x),
      .rsp_dest_y       (rsp_dest_y),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/ycbcr422_to_packed_rgb_test.sv =====
// Self-checking testbench for the YCbCr 4:2:2 to packed RGB converter.
// Drives pixel-pair transactions and register writes and checks every result against
// its own predictor; depends on y2r_pkg and the ycbcr422_to_packed_rgb top level.
`timescale 1ns / 1ps

module ycbcr422_to_packed_rgb_test;
   import y2r_pkg::*;

   localparam int LINE_MAX    = 1024;
   localparam int CYCLE_LIMIT = 200000;
   // Cycles allowed after the last expected result, covering a pair still in flight
   // that produces nothing.
   localparam int SETTLE      = 8;

   // One input transaction: a framebuffer word holding two pixels and its position.
   typedef struct packed {
      logic [31:0] word;
      logic [9:0]  col;
      logic [9:0]  row;
   } pair_item_type;

   // One result transaction as the converter should present it.
   typedef struct packed {
      logic [31:0] pixel;
      logic [9:0]  dx;
      logic [9:0]  dy;
      logic        last;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [31:0] req_pair_word = '0;
   logic [9:0]  req_column    = '0;
   logic [9:0]  req_row       = '0;

   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [31:0] rsp_packed_pixel;
   logic [9:0]  rsp_dest_x;
   logic [9:0]  rsp_dest_y;
   logic        rsp_last;

   logic        csr_psel      = 1'b0;
   logic        csr_penable   = 1'b0;
   logic        csr_pwrite    = 1'b0;
   logic [4:0]  csr_paddr     = '0;
   logic [31:0] csr_pwdata    = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Pairs waiting to be driven, and results that the converter still owes us.
   pair_item_type    pending_pairs[$];
   pixel_result_type pixel_expect_q[$];

   // Our own copy of the register file, updated as each write goes out.
   cfg_type cfg_mirror;

   pair_item_type    next_pair;
   pixel_result_type want;
   logic             req_fire = 1'b0;
   logic             steady   = 1'b0;
   int               mismatch_count = 0;

   ycbcr422_to_packed_rgb #(
      .LINE_MAX(LINE_MAX)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pair_word   (req_pair_word),
      .req_column      (req_column),
      .req_row         (req_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_pixel(rsp_packed_pixel),
      .rsp_dest_x      (rsp_dest_x),
      .rsp_dest_y      (rsp_dest_y),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Predictor. The colour maths is Q10 fixed point: a negative sum gives zero,
   // otherwise the sum is shifted down by ten bits and saturated at 255.
   // ---------------------------------------------------------------------------------
   function automatic logic [31:0] q10_clamp(input int sum);
      if (sum < 0) return 32'd0;
      sum = sum >>> 10;
      if (sum > 255) return 32'd255;
      return sum;
   endfunction

   // Widening of an 8-bit channel to 10 bits, rounded down.
   function automatic logic [31:0] widen10(input logic [31:0] c);
      return (c * 32'd1023) / 32'd255;
   endfunction

   // Converts one pixel and packs it into the currently selected format.
   function automatic logic [31:0] pack_rgb(input logic [7:0] yv, input logic [7:0] cb,
                                            input logic [7:0] cr);
      int          yt;
      logic [31:0] r, g, b, a, t;
      yt = int'(yv) * 1192;
      r  = q10_clamp(yt + int'(cr) * 1634 - 228271);
      g  = q10_clamp(yt - int'(cb) * 401 - int'(cr) * 832 + 138830);
      b  = q10_clamp(yt + int'(cb) * 2066 - 283480);
      a  = 32'd255;
      // BGR and BGRA layouts are handled by swapping the two outer channels first.
      if (cfg_mirror.swap_red_blue) begin
         t = r;
         r = b;
         b = t;
      end
      case (cfg_mirror.packed_type)
         FMT_332: begin
            return (r & 32'hE0) | ((g & 32'hE0) >> 3) | ((b & 32'hC0) >> 6);
         end
         FMT_233_REV: begin
            return (b & 32'hC0) | ((g & 32'hE0) >> 2) | ((r & 32'hE0) >> 5);
         end
         FMT_565: begin
            return ((r & 32'hF8) << 8) | ((g & 32'hFC) << 3) | ((b & 32'hF8) >> 3);
         end
         FMT_565_REV: begin
            return ((b & 32'hF8) << 8) | ((g & 32'hFC) << 3) | ((r & 32'hF8) >> 3);
         end
         FMT_4444: begin
            return ((r & 32'hF0) << 8) | ((g & 32'hF0) << 4) | (b & 32'hF0) |
                   ((a & 32'hF0) >> 4);
         end
         FMT_4444_REV: begin
            return ((a & 32'hF0) << 8) | ((b & 32'hF0) << 4) | (g & 32'hF0) |
                   ((r & 32'hF0) >> 4);
         end
         FMT_5551: begin
            return ((r & 32'hF8) << 8) | ((g & 32'hF8) << 3) | ((b & 32'hF8) >> 2) |
                   ((a & 32'h80) >> 7);
         end
         FMT_1555_REV: begin
            return ((a & 32'h80) << 8) | ((b & 32'hF8) << 7) | ((g & 32'hF8) << 2) |
                   ((r & 32'hF8) >> 3);
         end
         FMT_8888: begin
            return (r << 24) | (g << 16) | (b << 8) | a;
         end
         FMT_8888_REV: begin
            return (a << 24) | (b << 16) | (g << 8) | r;
         end
         FMT_1010102: begin
            return (widen10(r) << 22) | (widen10(g) << 12) | (widen10(b) << 2) | (a >> 6);
         end
         FMT_2101010_REV: begin
            return ((a >> 6) << 30) | (widen10(b) << 20) | (widen10(g) << 10) | widen10(r);
         end
         // Codes twelve to fifteen name no format and yield an all-zero word.
         default: begin
            return 32'd0;
         end
      endcase
   endfunction

   // Window membership; a pixel at or beyond the end of the line never counts.
   function automatic logic in_window(input int c, input int r);
      return c >= int'(cfg_mirror.window_x) &&
             c <  int'(cfg_mirror.window_x) + int'(cfg_mirror.window_width) &&
             r >= int'(cfg_mirror.window_y) &&
             r <  int'(cfg_mirror.window_y) + int'(cfg_mirror.window_height) &&
             c <  LINE_MAX;
   endfunction

   // ---------------------------------------------------------------------------------
   // Driver. Inputs move only at the falling edge, so the rising edge always sees a
   // settled transaction. A payload stays put until it has been taken.
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_pairs.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
            next_pair = pending_pairs.pop_front();
            req_valid     <= 1'b1;
            req_pair_word <= next_pair.word;
            req_column    <= next_pair.col;
            req_row       <= next_pair.row;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The result side applies back-pressure at random, except during the steady stretch.
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 9);
   end

   // ---------------------------------------------------------------------------------
   // Monitor and scoreboard. Results are checked first, then any pair taken at this
   // edge is turned into its expected results; the converter cannot answer a pair at
   // the edge that accepts it, so the order costs nothing.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: pixel %h x %0d y %0d last %b",
                           rsp_packed_pixel, rsp_dest_x, rsp_dest_y, rsp_last);
            end else begin
               want = pixel_expect_q.pop_front();
               if (rsp_packed_pixel !== want.pixel || rsp_dest_x !== want.dx ||
                   rsp_dest_y !== want.dy || rsp_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: got pixel %h x %0d y %0d last %b",
                              rsp_packed_pixel, rsp_dest_x, rsp_dest_y, rsp_last);
                     $display("          expected pixel %h x %0d y %0d last %b",
                              want.pixel, want.dx, want.dy, want.last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            // Both pixels share the chroma pair; the second sits one column to the right.
            // The last flag goes on the second emitted pixel, or on the only one if just one is emitted.
            if (in_window(int'(req_column), int'(req_row)))
               pixel_expect_q.push_back('{
                  pixel: pack_rgb(req_pair_word[31:24], req_pair_word[23:16],
                                  req_pair_word[7:0]),
                  dx:    req_column - cfg_mirror.window_x,
                  dy:    req_row - cfg_mirror.window_y,
                  last:  !in_window(int'(req_column) + 1, int'(req_row))});
            if (in_window(int'(req_column) + 1, int'(req_row)))
               pixel_expect_q.push_back('{
                  pixel: pack_rgb(req_pair_word[15:8], req_pair_word[23:16],
                                  req_pair_word[7:0]),
                  dx:    req_column + 10'd1 - cfg_mirror.window_x,
                  dy:    req_row - cfg_mirror.window_y,
                  last:  1'b1});
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Register access: a setup cycle, then an access cycle; pready is always high, so
   // the write lands at the rising edge inside the access cycle.
   // ---------------------------------------------------------------------------------
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_WINDOW_X:      cfg_mirror.window_x      = val[9:0];
         REG_WINDOW_Y:      cfg_mirror.window_y      = val[9:0];
         REG_WINDOW_WIDTH:  cfg_mirror.window_width  = val[10:0];
         REG_WINDOW_HEIGHT: cfg_mirror.window_height = val[10:0];
         REG_PACKED_TYPE:   cfg_mirror.packed_type   = val[3:0];
         REG_SWAP_RED_BLUE: cfg_mirror.swap_red_blue = val[0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int wx, input int wy, input int ww, input int wh,
                                input logic [3:0] fmt, input logic swap);
      csr_write(REG_WINDOW_X, wx);
      csr_write(REG_WINDOW_Y, wy);
      csr_write(REG_WINDOW_WIDTH, ww);
      csr_write(REG_WINDOW_HEIGHT, wh);
      csr_write(REG_PACKED_TYPE, {28'd0, fmt});
      csr_write(REG_SWAP_RED_BLUE, {31'd0, swap});
   endtask

   task automatic queue_pair(input logic [31:0] word, input int col, input int row);
      pending_pairs.push_back('{word: word, col: 10'(col), row: 10'(row)});
   endtask

   // Random pairs for the current setting. Most land on or just around the window so
   // that both, one or neither pixel is emitted; the rest roam the whole screen.
   task automatic queue_random_pairs(input int count);
      pair_item_type it;
      int            lo, hi, wx, wy, ww, wh;
      wx = cfg_mirror.window_x;
      wy = cfg_mirror.window_y;
      ww = cfg_mirror.window_width;
      wh = cfg_mirror.window_height;
      for (int n = 0; n < count; n++) begin
         it.word = $urandom;
         // Push the odd component to black or full scale so that clamping gets exercised.
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(7))
               0: it.word[8*k +: 8] = 8'h00;
               1: it.word[8*k +: 8] = 8'hFF;
               default: ;
            endcase
         end
         if ($urandom_range(99) < 80 && ww != 0 && wh != 0) begin
            lo = (wx > 1) ? wx - 2 : 0;
            hi = (wx + ww > 1023) ? 1023 : wx + ww;
            it.col = 10'($urandom_range(hi, lo));
            hi = (wy + wh - 1 > 1023) ? 1023 : wy + wh - 1;
            it.row = 10'($urandom_range(hi, wy));
         end else begin
            it.col = 10'($urandom_range(1023));
            it.row = 10'($urandom_range(1023));
         end
         pending_pairs.push_back(it);
      end
   endtask

   // Waits until every pair has gone in and every result has come out, then a little
   // longer in case the final pair produced nothing and is still moving through.
   task automatic drain();
      while (pending_pairs.size() != 0 || req_valid || pixel_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Stimulus sequence.
   // ---------------------------------------------------------------------------------
   initial begin
      int         wx, wy, ww, wh;
      logic [3:0] fmt;
      logic       swap;

      cfg_mirror = '{window_x: 10'd0, window_y: 10'd0, window_width: 11'd0,
                     window_height: 11'd0, packed_type: FMT_4444_REV, swap_red_blue: 1'b0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The reset window is empty, so this pair must vanish.
      queue_pair(32'h8080_8080, 0, 0);
      drain();

      // Full screen in plain 8888 so that every channel is visible unmasked: the
      // all-zero and all-ones words, black, white, saturated red and blue, an odd
      // column and a pair whose second pixel falls off the end of the line.
      apply_setting(0, 0, 1024, 1024, FMT_8888, 1'b0);
      queue_pair(32'h0000_0000, 0, 0);
      queue_pair(32'hFFFF_FFFF, 1022, 1023);
      queue_pair(32'hEB80_EB80, 10, 5);
      queue_pair(32'h1080_1080, 12, 6);
      queue_pair(32'h515A_51F0, 100, 200);
      queue_pair(32'h29F0_296E, 300, 400);
      queue_pair(32'h7F40_C0A0, 511, 512);
      queue_pair(32'hC020_40E0, 1023, 700);
      drain();

      // A one-column window: each pair either loses one pixel or both, and the last
      // flag must follow whichever pixel survives. Swapped red and blue, reversed
      // 2-10-10-10 format.
      apply_setting(7, 3, 1, 2, FMT_2101010_REV, 1'b1);
      queue_pair(32'hA05A_50F0, 6, 3);
      queue_pair(32'h30C0_D020, 7, 4);
      queue_pair(32'hFF00_00FF, 8, 3);
      queue_pair(32'h00FF_FF00, 6, 5);
      queue_pair(32'h8080_8080, 6, 2);
      drain();

      // A window of zero width gives nothing at all, here with an unassigned format code.
      apply_setting(0, 0, 0, 1024, 4'd15, 1'b0);
      queue_pair(32'hFFFF_FFFF, 0, 0);
      queue_pair(32'h1234_5678, 1022, 1023);
      drain();

      // Window anchored at the far corner: only column 1023 of row 1023 is inside.
      apply_setting(1023, 1023, 1024, 1024, FMT_1010102, 1'b0);
      queue_pair(32'hEB10_EBF0, 1022, 1023);
      queue_pair(32'h10F0_EB10, 1023, 1023);
      drain();

      // Random phases. The first sixteen walk through every format code, the window
      // shape cycles through full screen, random, tiny, far corner and possibly empty.
      for (int p = 0; p < 18; p++) begin
         steady = (p == 6 || p == 7);
         fmt  = (p < 16) ? p[3:0] : 4'($urandom_range(15));
         swap = (p < 16) ? p[1] : 1'($urandom_range(1));
         case (p % 5)
            0: begin
               wx = 0;    wy = 0;    ww = 1024; wh = 1024;
            end
            1: begin
               wx = $urandom_range(1023);      wy = $urandom_range(1023);
               ww = $urandom_range(1024, 1);   wh = $urandom_range(1024, 1);
            end
            2: begin
               wx = $urandom_range(1023);      wy = $urandom_range(1023);
               ww = $urandom_range(4, 1);      wh = $urandom_range(4, 1);
            end
            3: begin
               wx = 1023; wy = 1023; ww = 1024; wh = 1024;
            end
            default: begin
               wx = $urandom_range(1023);      wy = $urandom_range(1023);
               ww = $urandom_range(1024);      wh = $urandom_range(1024);
            end
         endcase
         apply_setting(wx, wy, ww, wh, fmt, swap);
         queue_random_pairs(58);
         drain();
      end
      steady = 1'b0;

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ycbcr422_to_packed_rgb_test: done, clean");
      end else begin
         $display("ycbcr422_to_packed_rgb_test: done, errors");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   initial begin
      for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clock);
      $display("ycbcr422_to_packed_rgb_test: done, errors");
      $finish;
   end

endmodule

// ===== ycbcr422_to_packed_rgb.f =====
hw/rtl/y2r_pkg.sv
hw/rtl/y2r_csr.sv
hw/rtl/y2r_lane.sv
hw/rtl/y2r_merge.sv
hw/rtl/ycbcr422_to_packed_rgb.sv
tb/ycbcr422_to_packed_rgb_test.sv
